[rtl/core/i2cms_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
package i2cms_pkg;

   localparam int BYTE_BITS = 8;
   localparam int PHASE_TICKS_W = 16;
   localparam int ACK_TIMEOUT_W = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RESET = 16'd10;
   localparam logic [ACK_TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 8'd250;

   typedef enum logic [2:0] {
      CMD_NONE     = 3'd0,
      CMD_START    = 3'd1,
      CMD_STOP     = 3'd2,
      CMD_WRITE    = 3'd3,
      CMD_READ     = 3'd4,
      CMD_WAIT_ACK = 3'd5
   } cmd_type;

   typedef enum logic {
      CSR_PHASE_TICKS = 1'b0,
      CSR_ACK_TIMEOUT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PHASE_TICKS_W-1:0] phase_ticks;
      logic [ACK_TIMEOUT_W-1:0] ack_timeout;
   } cfg_type;

   typedef struct packed {
      logic                 scl_level;
      logic                 sda_level;
      logic                 sda_drive;
      logic                 busy_res;
      logic                 done_res;
      logic [BYTE_BITS-1:0] rx_byte;
      logic                 ack_failed;
   } result_type;

endpackage

[rtl/core/i2cms_engine.sv]
// Bus phase sequencer that advances the I2C master state by one tick per item.
module i2cms_engine
   import i2cms_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [2:0]           command,
   input  logic [BYTE_BITS-1:0] tx_byte,
   input  logic                 send_ack,
   input  logic                 sda_in,
   input  cfg_type              cfg,
   output result_type           result
);

   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_ST_A     = 5'd1,
      PH_ST_B     = 5'd2,
      PH_ST_C     = 5'd3,
      PH_SP_A     = 5'd4,
      PH_SP_B     = 5'd5,
      PH_SP_C     = 5'd6,
      PH_WR_LOW   = 5'd7,
      PH_WR_HIGH  = 5'd8,
      PH_WR_TAIL  = 5'd9,
      PH_RD_LOW   = 5'd10,
      PH_RD_HIGH  = 5'd11,
      PH_AK_LOW   = 5'd12,
      PH_AK_HIGH  = 5'd13,
      PH_WA_SETUP = 5'd14,
      PH_WA_HIGH  = 5'd15,
      PH_WA_POLL  = 5'd16
   } phase_type;

   typedef struct packed {
      phase_type                phase;
      logic [2:0]               bit_index;
      logic [PHASE_TICKS_W-1:0] timer;
      logic [BYTE_BITS-1:0]     shift;
      logic [ACK_TIMEOUT_W-1:0] wait_count;
      logic                     scl;
      logic                     sda;
      logic                     drive;
      logic [BYTE_BITS-1:0]     rx;
      logic                     ack_fail;
      logic                     ack_choice;
   } state_type;

   localparam logic [2:0] LAST_BIT = 3'(BYTE_BITS - 1);

   state_type                st_ff;
   state_type                st_in;
   logic                     done;
   logic [PHASE_TICKS_W-1:0] load;

   // Entering a phase reloads the phase timer and sets the pins for that phase.
   function automatic state_type enter_phase(state_type s, phase_type ph,
                                             logic [PHASE_TICKS_W-1:0] ld);
      state_type r;
      r = s;
      r.phase = ph;
      r.timer = ld;
      case (ph)
         PH_ST_A: begin
            r.drive = 1'b1;
            r.sda = 1'b1;
            r.scl = 1'b1;
         end
         PH_ST_B: r.sda = 1'b0;
         PH_ST_C: r.scl = 1'b0;
         PH_SP_A: begin
            r.drive = 1'b1;
            r.scl = 1'b0;
            r.sda = 1'b0;
         end
         PH_SP_B: r.scl = 1'b1;
         PH_SP_C: r.sda = 1'b1;
         PH_WR_LOW: begin
            r.drive = 1'b1;
            r.scl = 1'b0;
            r.sda = s.shift[BYTE_BITS-1];
         end
         PH_WR_HIGH: r.scl = 1'b1;
         PH_WR_TAIL: r.scl = 1'b0;
         PH_RD_LOW: begin
            r.drive = 1'b0;
            r.scl = 1'b0;
         end
         PH_RD_HIGH: r.scl = 1'b1;
         PH_AK_LOW: begin
            r.scl = 1'b0;
            r.drive = 1'b1;
            r.sda = ~s.ack_choice;
         end
         PH_AK_HIGH: r.scl = 1'b1;
         PH_WA_SETUP: begin
            r.drive = 1'b0;
            r.sda = 1'b1;
         end
         PH_WA_HIGH: r.scl = 1'b1;
         default: ;
      endcase
      return r;
   endfunction

   always_comb begin
      st_in = st_ff;
      done = 1'b0;
      load = (cfg.phase_ticks == '0) ? PHASE_TICKS_W'(1) : cfg.phase_ticks;
      case (st_ff.phase)
         PH_IDLE: begin
            case (command)
               CMD_START: st_in = enter_phase(st_in, PH_ST_A, load);
               CMD_STOP:  st_in = enter_phase(st_in, PH_SP_A, load);
               CMD_WRITE: begin
                  st_in.shift = tx_byte;
                  st_in.bit_index = '0;
                  st_in = enter_phase(st_in, PH_WR_LOW, load);
               end
               CMD_READ: begin
                  st_in.shift = '0;
                  st_in.bit_index = '0;
                  st_in.ack_choice = send_ack;
                  st_in = enter_phase(st_in, PH_RD_LOW, load);
               end
               CMD_WAIT_ACK: begin
                  st_in.wait_count = '0;
                  st_in = enter_phase(st_in, PH_WA_SETUP, load);
               end
               default: ;
            endcase
         end
         PH_WA_POLL: begin
            if (!sda_in) begin
               st_in.scl = 1'b0;
               st_in.ack_fail = 1'b0;
               st_in.phase = PH_IDLE;
               done = 1'b1;
            end else if (st_ff.wait_count >= cfg.ack_timeout) begin
               st_in.ack_fail = 1'b1;
               st_in = enter_phase(st_in, PH_SP_A, load);
            end else begin
               st_in.wait_count = st_ff.wait_count + ACK_TIMEOUT_W'(1);
            end
         end
         default: begin
            if (st_ff.timer <= PHASE_TICKS_W'(1)) begin
               st_in.timer = '0;
               case (st_ff.phase)
                  PH_ST_A:    st_in = enter_phase(st_in, PH_ST_B, load);
                  PH_ST_B:    st_in = enter_phase(st_in, PH_ST_C, load);
                  PH_SP_A:    st_in = enter_phase(st_in, PH_SP_B, load);
                  PH_SP_B:    st_in = enter_phase(st_in, PH_SP_C, load);
                  PH_WR_LOW:  st_in = enter_phase(st_in, PH_WR_HIGH, load);
                  PH_WR_HIGH: st_in = enter_phase(st_in, PH_WR_TAIL, load);
                  PH_WR_TAIL: begin
                     st_in.shift = {st_ff.shift[BYTE_BITS-2:0], 1'b0};
                     if (st_ff.bit_index >= LAST_BIT) begin
                        st_in.phase = PH_IDLE;
                        done = 1'b1;
                     end else begin
                        st_in.bit_index = st_ff.bit_index + 3'd1;
                        st_in = enter_phase(st_in, PH_WR_LOW, load);
                     end
                  end
                  PH_RD_LOW:  st_in = enter_phase(st_in, PH_RD_HIGH, load);
                  PH_RD_HIGH: begin
                     st_in.shift = {st_ff.shift[BYTE_BITS-2:0], sda_in};
                     if (st_ff.bit_index >= LAST_BIT) begin
                        st_in.rx = st_in.shift;
                        st_in = enter_phase(st_in, PH_AK_LOW, load);
                     end else begin
                        st_in.bit_index = st_ff.bit_index + 3'd1;
                        st_in = enter_phase(st_in, PH_RD_LOW, load);
                     end
                  end
                  PH_AK_LOW:  st_in = enter_phase(st_in, PH_AK_HIGH, load);
                  PH_AK_HIGH: begin
                     st_in.scl = 1'b0;
                     st_in.phase = PH_IDLE;
                     done = 1'b1;
                  end
                  PH_WA_SETUP: st_in = enter_phase(st_in, PH_WA_HIGH, load);
                  PH_WA_HIGH: begin
                     st_in.phase = PH_WA_POLL;
                     st_in.timer = '0;
                  end
                  PH_ST_C, PH_SP_C: begin
                     st_in.phase = PH_IDLE;
                     done = 1'b1;
                  end
                  default: st_in.phase = PH_IDLE;
               endcase
            end else begin
               st_in.timer = st_ff.timer - PHASE_TICKS_W'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.phase      <= PH_IDLE;
         st_ff.bit_index  <= '0;
         st_ff.timer      <= '0;
         st_ff.shift      <= '0;
         st_ff.wait_count <= '0;
         st_ff.scl        <= 1'b1;
         st_ff.sda        <= 1'b1;
         st_ff.drive      <= 1'b1;
         st_ff.rx         <= '0;
         st_ff.ack_fail   <= 1'b0;
         st_ff.ack_choice <= 1'b0;
      end else if (step) begin
         st_ff <= st_in;
      end
   end

   always_comb begin
      result.scl_level  = st_in.scl;
      result.sda_level  = st_in.sda;
      result.sda_drive  = st_in.drive;
      result.busy_res   = (st_in.phase != PH_IDLE);
      result.done_res   = done;
      result.rx_byte    = st_in.rx;
      result.ack_failed = st_in.ack_fail;
   end

endmodule

[rtl/core/i2c_master_bit_sequencer.sv]
// Top level of the I2C master bit sequencer: configuration, handshakes and result register.
// The result of an item is registered and presented in the cycle after the item is accepted.
// Throughput: one item per cycle unless stalled; a tick is one combinational engine pass.
// The input is stalled only while a result is held and the result side stalls.
// Synchronous active-high reset: idle phase, SCL and SDA high and driven, counters cleared,
// phase_ticks 10, ack_timeout 250, no result pending.
module i2c_master_bit_sequencer
   import i2cms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_command,
   input  logic [BYTE_BITS-1:0]  req_tx_byte,
   input  logic                  req_send_ack,
   input  logic                  req_sda_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_scl_level,
   output logic                  rsp_sda_level,
   output logic                  rsp_sda_drive,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic [BYTE_BITS-1:0]  rsp_rx_byte,
   output logic                  rsp_ack_failed,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   result_type res_in;
   result_type res_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;

   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks <= PHASE_TICKS_RESET;
         cfg_ff.ack_timeout <= ACK_TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PHASE_TICKS: cfg_ff.phase_ticks <= csr_wdata[PHASE_TICKS_W-1:0];
            CSR_ACK_TIMEOUT: cfg_ff.ack_timeout <= csr_wdata[ACK_TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   i2cms_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .command  (req_command),
      .tx_byte  (req_tx_byte),
      .send_ack (req_send_ack),
      .sda_in   (req_sda_in),
      .cfg      (cfg_ff),
      .result   (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_level  = res_ff.scl_level;
   assign rsp_sda_level  = res_ff.sda_level;
   assign rsp_sda_drive  = res_ff.sda_drive;
   assign rsp_busy_res   = res_ff.busy_res;
   assign rsp_done_res   = res_ff.done_res;
   assign rsp_rx_byte    = res_ff.rx_byte;
   assign rsp_ack_failed = res_ff.ack_failed;

endmodule

[verif/i2cms_bus_checker.sv]
// Checker for the I2C master bit sequencer: predicts the bus state of every tick and compares.
module i2cms_bus_checker
   import i2cms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [2:0]            req_command,
   input  logic [BYTE_BITS-1:0]  req_tx_byte,
   input  logic                  req_send_ack,
   input  logic                  req_sda_in,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_scl_level,
   input  logic                  rsp_sda_level,
   input  logic                  rsp_sda_drive,
   input  logic                  rsp_busy_res,
   input  logic                  rsp_done_res,
   input  logic [BYTE_BITS-1:0]  rsp_rx_byte,
   input  logic                  rsp_ack_failed,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    ticks_pending,
   output int                    commands_taken,
   output logic                  engine_idle
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_START_A,
      ST_START_B,
      ST_START_C,
      ST_STOP_A,
      ST_STOP_B,
      ST_STOP_C,
      ST_WR_LOW,
      ST_WR_HIGH,
      ST_WR_TAIL,
      ST_RD_LOW,
      ST_RD_HIGH,
      ST_ACK_LOW,
      ST_ACK_HIGH,
      ST_WA_SETUP,
      ST_WA_HIGH,
      ST_WA_POLL
   } step_type;

   cfg_type                   cfg;
   step_type                  step;
   logic [2:0]                bit_idx;
   logic [PHASE_TICKS_W-1:0]  timer;
   logic [BYTE_BITS-1:0]      shifter;
   logic [BYTE_BITS-1:0]      rx_hold;
   logic [ACK_TIMEOUT_W-1:0]  polls;
   logic                      scl;
   logic                      sda;
   logic                      drive;
   logic                      ack_fail;
   logic                      ack_choice;
   int                        started = 0;
   int                        mismatches = 0;
   result_type                bus_states[$];
   result_type                seen;
   result_type                want;

   task automatic note_mismatch(input string msg);
      if (mismatches < 100) begin
         $display("i2cms checker: %s at %0t", msg, $time);
      end
      mismatches++;
   endtask

   function automatic void enter_step(input step_type nxt);
      step = nxt;
      timer = (cfg.phase_ticks == '0) ? 16'd1 : cfg.phase_ticks;
      case (nxt)
         ST_START_A: begin
            drive = 1'b1;
            sda = 1'b1;
            scl = 1'b1;
         end
         ST_START_B: sda = 1'b0;
         ST_START_C: scl = 1'b0;
         ST_STOP_A: begin
            drive = 1'b1;
            scl = 1'b0;
            sda = 1'b0;
         end
         ST_STOP_B: scl = 1'b1;
         ST_STOP_C: sda = 1'b1;
         ST_WR_LOW: begin
            drive = 1'b1;
            scl = 1'b0;
            sda = shifter[BYTE_BITS-1];
         end
         ST_WR_HIGH: scl = 1'b1;
         ST_WR_TAIL: scl = 1'b0;
         ST_RD_LOW: begin
            drive = 1'b0;
            scl = 1'b0;
         end
         ST_RD_HIGH: scl = 1'b1;
         ST_ACK_LOW: begin
            scl = 1'b0;
            drive = 1'b1;
            sda = ~ack_choice;
         end
         ST_ACK_HIGH: scl = 1'b1;
         ST_WA_SETUP: begin
            drive = 1'b0;
            sda = 1'b1;
         end
         ST_WA_HIGH: scl = 1'b1;
         default: ;
      endcase
   endfunction

   function automatic logic end_of_step(input logic sda_s);
      logic fin;
      fin = 1'b0;
      case (step)
         ST_START_A: enter_step(ST_START_B);
         ST_START_B: enter_step(ST_START_C);
         ST_STOP_A: enter_step(ST_STOP_B);
         ST_STOP_B: enter_step(ST_STOP_C);
         ST_WR_LOW: enter_step(ST_WR_HIGH);
         ST_WR_HIGH: enter_step(ST_WR_TAIL);
         ST_WR_TAIL: begin
            shifter = shifter << 1;
            if (bit_idx >= 3'(BYTE_BITS - 1)) begin
               step = ST_IDLE;
               fin = 1'b1;
            end else begin
               bit_idx = bit_idx + 3'd1;
               enter_step(ST_WR_LOW);
            end
         end
         ST_RD_LOW: enter_step(ST_RD_HIGH);
         ST_RD_HIGH: begin
            shifter = {shifter[BYTE_BITS-2:0], sda_s};
            if (bit_idx >= 3'(BYTE_BITS - 1)) begin
               rx_hold = shifter;
               enter_step(ST_ACK_LOW);
            end else begin
               bit_idx = bit_idx + 3'd1;
               enter_step(ST_RD_LOW);
            end
         end
         ST_ACK_LOW: enter_step(ST_ACK_HIGH);
         ST_ACK_HIGH: begin
            scl = 1'b0;
            step = ST_IDLE;
            fin = 1'b1;
         end
         ST_WA_SETUP: enter_step(ST_WA_HIGH);
         ST_WA_HIGH: begin
            step = ST_WA_POLL;
            timer = '0;
         end
         ST_START_C, ST_STOP_C: begin
            step = ST_IDLE;
            fin = 1'b1;
         end
         default: step = ST_IDLE;
      endcase
      return fin;
   endfunction

   function automatic result_type bus_tick(input logic [2:0] cmd,
                                           input logic [BYTE_BITS-1:0] txb,
                                           input logic sack, input logic sda_s);
      result_type r;
      logic fin;
      fin = 1'b0;
      if (step == ST_IDLE) begin
         case (cmd)
            CMD_START: enter_step(ST_START_A);
            CMD_STOP: enter_step(ST_STOP_A);
            CMD_WRITE: begin
               shifter = txb;
               bit_idx = '0;
               enter_step(ST_WR_LOW);
            end
            CMD_READ: begin
               shifter = '0;
               bit_idx = '0;
               ack_choice = sack;
               enter_step(ST_RD_LOW);
            end
            CMD_WAIT_ACK: begin
               polls = '0;
               enter_step(ST_WA_SETUP);
            end
            default: ;
         endcase
         if (step != ST_IDLE) begin
            started++;
         end
      end else if (step == ST_WA_POLL) begin
         if (!sda_s) begin
            scl = 1'b0;
            ack_fail = 1'b0;
            step = ST_IDLE;
            fin = 1'b1;
         end else if (polls >= cfg.ack_timeout) begin
            ack_fail = 1'b1;
            enter_step(ST_STOP_A);
         end else begin
            polls = polls + 8'd1;
         end
      end else if (timer <= 16'd1) begin
         timer = '0;
         fin = end_of_step(sda_s);
      end else begin
         timer = timer - 16'd1;
      end
      r.scl_level = scl;
      r.sda_level = sda;
      r.sda_drive = drive;
      r.busy_res = (step != ST_IDLE);
      r.done_res = fin;
      r.rx_byte = rx_hold;
      r.ack_failed = ack_fail;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.phase_ticks = PHASE_TICKS_RESET;
         cfg.ack_timeout = ACK_TIMEOUT_RESET;
         step = ST_IDLE;
         bit_idx = '0;
         timer = '0;
         shifter = '0;
         polls = '0;
         scl = 1'b1;
         sda = 1'b1;
         drive = 1'b1;
         rx_hold = '0;
         ack_fail = 1'b0;
         ack_choice = 1'b0;
         bus_states.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{scl_level: rsp_scl_level, sda_level: rsp_sda_level,
                     sda_drive: rsp_sda_drive, busy_res: rsp_busy_res,
                     done_res: rsp_done_res, rx_byte: rsp_rx_byte,
                     ack_failed: rsp_ack_failed};
            if (bus_states.size() == 0) begin
               note_mismatch("result arrived with no tick outstanding");
            end else begin
               want = bus_states.pop_front();
               if (seen.scl_level !== want.scl_level)
                  note_mismatch($sformatf("scl_level %b, expected %b",
                                          seen.scl_level, want.scl_level));
               if (seen.sda_level !== want.sda_level)
                  note_mismatch($sformatf("sda_level %b, expected %b",
                                          seen.sda_level, want.sda_level));
               if (seen.sda_drive !== want.sda_drive)
                  note_mismatch($sformatf("sda_drive %b, expected %b",
                                          seen.sda_drive, want.sda_drive));
               if (seen.busy_res !== want.busy_res)
                  note_mismatch($sformatf("busy_res %b, expected %b",
                                          seen.busy_res, want.busy_res));
               if (seen.done_res !== want.done_res)
                  note_mismatch($sformatf("done_res %b, expected %b",
                                          seen.done_res, want.done_res));
               if (seen.rx_byte !== want.rx_byte)
                  note_mismatch($sformatf("rx_byte %h, expected %h",
                                          seen.rx_byte, want.rx_byte));
               if (seen.ack_failed !== want.ack_failed)
                  note_mismatch($sformatf("ack_failed %b, expected %b",
                                          seen.ack_failed, want.ack_failed));
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_PHASE_TICKS: cfg.phase_ticks = csr_wdata;
               CSR_ACK_TIMEOUT: cfg.ack_timeout = csr_wdata[ACK_TIMEOUT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            bus_states.push_back(bus_tick(req_command, req_tx_byte, req_send_ack,
                                          req_sda_in));
         end
      end
      error_count <= mismatches;
      ticks_pending <= bus_states.size();
      commands_taken <= started;
      engine_idle <= (step == ST_IDLE);
   end

endmodule

[verif/tb_top.sv]
// Testbench top for the I2C master bit sequencer: stimulus, idling, register writes and verdict.
module tb_top;
   import i2cms_pkg::*;

   localparam int         CYCLE_LIMIT = 2_000_000;
   localparam int         HOLD_CYCLES = 400;
   localparam int         TICKS_PER_PHASE = 20;
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [2:0]            req_command;
   logic [BYTE_BITS-1:0]  req_tx_byte;
   logic                  req_send_ack;
   logic                  req_sda_in;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_scl_level;
   logic                  rsp_sda_level;
   logic                  rsp_sda_drive;
   logic                  rsp_busy_res;
   logic                  rsp_done_res;
   logic [BYTE_BITS-1:0]  rsp_rx_byte;
   logic                  rsp_ack_failed;
   logic                  csr_write;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int                    error_count;
   int                    ticks_pending;
   int                    commands_taken;
   logic                  engine_idle;

   int                    gap_pct;
   int                    stall_pct;
   int                    hold_requests;
   int                    holds_served;
   int                    hold_left;
   int                    ticks_sent;
   int                    cfg_writes;
   int                    cycle_count;

   i2c_master_bit_sequencer dut (.*);

   i2cms_bus_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      rsp_stall <= 1'b0;
      holds_served = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   function automatic logic pick_sda(input int low_pct);
      return ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1;
   endfunction

   task automatic offer_tick(input logic [2:0] cmd, input logic [BYTE_BITS-1:0] txb,
                             input logic sack, input logic sda);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_tx_byte <= txb;
      req_send_ack <= sack;
      req_sda_in <= sda;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   // The command is offered until the engine takes it; the engine stays busy for at least
   // three ticks, so the repeated offer and the one random command after it are ignored.
   task automatic run_cmd(input logic [2:0] cmd, input logic [BYTE_BITS-1:0] txb,
                          input logic sack, input int low_pct);
      int taken_before;
      taken_before = commands_taken;
      if (cmd < CMD_START || cmd > CMD_WAIT_ACK) begin
         offer_tick(cmd, txb, sack, pick_sda(low_pct));
      end else begin
         while (commands_taken == taken_before)
            offer_tick(cmd, txb, sack, pick_sda(low_pct));
         offer_tick(3'($urandom_range(7)), 8'($urandom), 1'($urandom), pick_sda(low_pct));
         while (!engine_idle)
            offer_tick(CMD_NONE, 8'($urandom), 1'($urandom), pick_sda(low_pct));
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (ticks_pending != 0 || !engine_idle);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_cfg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      cfg_writes++;
   endtask

   // Mostly complete transfers with random content; the rest are random commands.
   task automatic random_traffic(input int budget);
      int stop_at;
      stop_at = ticks_sent + budget;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(9) < 2) begin
            run_cmd(3'($urandom_range(7)), 8'($urandom), 1'($urandom), $urandom_range(100));
         end else begin
            run_cmd(CMD_START, 8'($urandom), 1'($urandom), 50);
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(1) == 1) begin
                  run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), 50);
                  run_cmd(CMD_WAIT_ACK, 8'($urandom), 1'($urandom), 35);
               end else begin
                  run_cmd(CMD_READ, 8'($urandom), 1'($urandom), 50);
               end
            end
            run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), 50);
         end
      end
   endtask

   initial begin
      int p;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_NONE;
      req_tx_byte <= '0;
      req_send_ack <= 1'b0;
      req_sda_in <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= CSR_PHASE_TICKS;
      csr_wdata <= '0;
      gap_pct = 0;
      ticks_sent = 0;
      cfg_writes = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values of the registers: every command, both acknowledge outcomes.
      run_cmd(CMD_START, 8'h00, 1'b0, 50);
      run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 100);
      run_cmd(CMD_WRITE, 8'h00, 1'b1, 50);
      run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 0);
      run_cmd(CMD_READ, 8'h00, 1'b1, 50);
      run_cmd(CMD_READ, 8'hFF, 1'b0, 50);
      run_cmd(CMD_STOP, 8'h00, 1'b0, 50);
      run_cmd(CMD_NONE, 8'hFF, 1'b1, 50);
      run_cmd(CMD_SPARE_6, 8'hFF, 1'b1, 50);
      run_cmd(CMD_SPARE_7, 8'h00, 1'b0, 50);
      settle();

      // Zero phase length acts as one; zero timeout fails on the first high poll.
      write_cfg(CSR_PHASE_TICKS, 16'd0);
      write_cfg(CSR_ACK_TIMEOUT, 16'd0);
      run_cmd(CMD_START, 8'h00, 1'b0, 50);
      run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 0);
      run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 100);
      run_cmd(CMD_READ, 8'h00, 1'b1, 50);
      run_cmd(CMD_WRITE, 8'hA5, 1'b0, 50);
      run_cmd(CMD_STOP, 8'h00, 1'b0, 50);
      settle();

      for (p = 0; p < 8; p++) begin
         write_cfg(CSR_PHASE_TICKS, 16'($urandom_range(1, 3)));
         write_cfg(CSR_ACK_TIMEOUT, (p == 6) ? 16'd255 : 16'($urandom_range(0, 10)));
         case (p % 4)
            0: begin
               gap_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               gap_pct = 86;
               stall_pct <= 0;
            end
            2: begin
               gap_pct = 0;
               stall_pct <= 86;
            end
            default: begin
               gap_pct = 24;
               stall_pct <= 24;
            end
         endcase
         if (p == 4) begin
            hold_requests <= hold_requests + 1;
         end
         random_traffic(TICKS_PER_PHASE);
         settle();
      end

      gap_pct = 0;
      stall_pct <= 0;
      write_cfg(CSR_PHASE_TICKS, 16'd40);
      run_cmd(CMD_START, 8'h00, 1'b0, 50);
      settle();
      write_cfg(CSR_PHASE_TICKS, 16'd1);
      write_cfg(CSR_ACK_TIMEOUT, 16'd255);
      run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 0);
      run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 2);
      settle();

      $display("tb_top: %0d ticks sent, %0d commands started, %0d register writes, %0d cycles",
               ticks_sent, commands_taken, cfg_writes, cycle_count);
      $display("tb_top: phase lengths 0 to 40, acknowledge timeouts 0 to 255, four idle mixes");
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
